FILE: hdl/ple_pkg.sv
// Types and constants shared by the positional list engine.
// No dependencies; compile first.
package ple_pkg;

    // Operation selector codes
    localparam logic [2:0] FN_APPEND  = 3'd0;
    localparam logic [2:0] FN_INSERT  = 3'd1;
    localparam logic [2:0] FN_REM_AT  = 3'd2;
    localparam logic [2:0] FN_REM_VAL = 3'd3;
    localparam logic [2:0] FN_REPLACE = 3'd4;
    localparam logic [2:0] FN_FIND    = 3'd5;
    localparam logic [2:0] FN_READ    = 3'd6;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [7:0]  position;
        logic signed [31:0] item_value;
    } in_beat_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] out_value;
        logic [5:0]         out_index;
        logic [6:0]         count_after;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_GETV,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        WA_COUNT,
        WA_P,
        WA_IDX
    } waddr_sel_t;

    typedef enum logic [1:0] {
        RA_P,
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_P1
    } raddr_sel_t;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_P,
        IDX_ZERO
    } idx_load_t;

    typedef struct packed {
        logic       latch;
        logic       clear_res;
        logic       we;
        waddr_sel_t waddr;
        logic       wd_rdata;
        raddr_sel_t raddr;
        idx_load_t  idx_ld;
        logic       idx_inc;
        logic       idx_dec;
        logic       count_inc;
        logic       count_dec;
        logic       set_ok;
        logic       cap_rval;
        logic       cap_sval;
        logic       cap_idx;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       room;
        logic       pos_le;
        logic       pos_lt;
        logic       idx_eq_p;
        logic       idx_last;
        logic       scan_end;
        logic       match;
        logic       out_free;
    } status_t;

endpackage

FILE: hdl/ple_in_if.sv
// Request channel of the positional list engine.
// Depends on ple_pkg.
interface ple_in_if;
    logic              valid;
    logic              ready;
    ple_pkg::in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ple_out_if.sv
// Response channel of the positional list engine.
// Depends on ple_pkg.
interface ple_out_if;
    logic               valid;
    logic               ready;
    ple_pkg::out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/positional_list_engine_core.sv
// Top level of the positional list engine: sequencer plus datapath.
// Depends on ple_pkg, ple_in_if, ple_out_if, ple_ctrl, ple_dp.
//
// An ordered list of up to CAPACITY signed 32-bit values held in one
// single-write, single-read RAM. Each request beat gives exactly one response
// beat. The block takes one request at a time: append, replace and requests
// refused at evaluation go straight to the done state; read first fetches
// the value; find and remove by value examine each element with a RAM read
// state and a compare state; insert and remove at a position move each
// trailing element with one RAM read and one RAM write, as the RAM has a
// single, registered read port. A new request is accepted while the
// previous response still waits to be taken.
module positional_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input logic     clk,
    input logic     rst_n,
    ple_in_if.sink  req,
    ple_out_if.source rsp
);
    import ple_pkg::*;

    cmd_t    cmd;
    status_t st;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );
endmodule

FILE: hdl/ple_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/ple_ctrl.sv
// Sequencer of the positional list engine: steps each operation through
// evaluation, scan and shift phases. Depends on ple_pkg.
module ple_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ple_pkg::status_t st,
    output ple_pkg::cmd_t    cmd
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decide the next state and issue commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.clear_res = 1'b1;
                state_next    = S_DONE;
                case (st.func) inside
                    FN_APPEND:
                    begin
                        if (st.room)
                        begin
                            cmd.we        = 1'b1;
                            cmd.waddr     = WA_COUNT;
                            cmd.count_inc = 1'b1;
                            cmd.set_ok    = 1'b1;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (st.room && st.pos_le)
                        begin
                            cmd.idx_ld = IDX_COUNT;
                            cmd.set_ok = 1'b1;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    FN_REM_AT, FN_READ:
                    begin
                        if (st.pos_lt)
                        begin
                            cmd.raddr  = RA_P;
                            cmd.idx_ld = IDX_P;
                            cmd.set_ok = 1'b1;
                            state_next = S_GETV;
                        end
                    end
                    FN_REM_VAL, FN_FIND:
                    begin
                        cmd.idx_ld = IDX_ZERO;
                        state_next = S_SCAN_RD;
                    end
                    FN_REPLACE:
                    begin
                        if (st.pos_lt)
                        begin
                            cmd.we     = 1'b1;
                            cmd.waddr  = WA_P;
                            cmd.set_ok = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_GETV:
            begin
                cmd.cap_rval = 1'b1;
                state_next   = (st.func == FN_READ) ? S_DONE : S_SHIFT_RD;
            end
            S_SCAN_RD:
            begin
                if (st.scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.raddr  = RA_IDX;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (st.match)
                begin
                    cmd.set_ok  = 1'b1;
                    cmd.cap_idx = 1'b1;
                    if (st.func == FN_REM_VAL)
                    begin
                        cmd.cap_sval = 1'b1;
                        state_next   = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (st.func == FN_INSERT)
                begin
                    if (st.idx_eq_p)
                    begin
                        cmd.we        = 1'b1;
                        cmd.waddr     = WA_P;
                        cmd.count_inc = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.raddr  = RA_IDX_M1;
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (st.idx_last)
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        cmd.raddr  = RA_IDX_P1;
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                cmd.we       = 1'b1;
                cmd.waddr    = WA_IDX;
                cmd.wd_rdata = 1'b1;
                if (st.func == FN_INSERT)
                begin
                    cmd.idx_dec = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: hdl/ple_dp.sv
// Datapath of the positional list engine: element RAM, count, walking index,
// position resolution and the response register. Depends on ple_pkg, ple_ram.
module ple_dp #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ple_pkg::in_beat_t  in_data,
    input  ple_pkg::cmd_t      cmd,
    output ple_pkg::status_t   st,
    output logic               out_valid,
    input  logic               out_ready,
    output ple_pkg::out_beat_t out_data
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = ((CW > 8) ? CW : 8) + 2;
    localparam int XW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [2:0]        func_reg;
    logic signed [7:0] pos_reg;
    logic [31:0]       val_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic              ok_reg;
    logic [31:0]       oval_reg;
    logic [CW-1:0]     oidx_reg;
    logic              out_valid_reg;
    out_beat_t         out_reg;

    logic signed [SW-1:0] pos_s;
    logic signed [SW-1:0] cnt_s;
    logic signed [SW-1:0] res_s;
    logic                 res_ok;
    logic [AW-1:0]        p_idx;
    logic [CW-1:0]        idx_m1;
    logic [CW-1:0]        idx_p1;
    logic [CW:0]          idx_p1_w;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [31:0]          wdata;
    logic [AW-1:0]        raddr;
    logic [31:0]          rdata;
    logic [XW-1:0]        oidx_x;
    logic [XW-1:0]        cnt_x;

    // Resolve the signed position against the count
    always_comb
    begin
        pos_s  = SW'(pos_reg);
        cnt_s  = signed'({{(SW-CW){1'b0}}, count_reg});
        res_s  = (pos_s < 0) ? (pos_s + cnt_s) : pos_s;
        res_ok = (pos_s <= cnt_s) && (res_s >= 0);
    end

    assign p_idx    = res_s[AW-1:0];
    assign idx_m1   = idx_reg - 1'b1;
    assign idx_p1_w = {1'b0, idx_reg} + 1'b1;
    assign idx_p1   = idx_p1_w[CW-1:0];

    // Pack status for the sequencer
    always_comb
    begin
        st.func     = func_reg;
        st.room     = count_reg < CAP_C;
        st.pos_le   = res_ok && (res_s <= cnt_s);
        st.pos_lt   = res_ok && (res_s < cnt_s);
        st.idx_eq_p = idx_reg == CW'(p_idx);
        st.idx_last = idx_p1_w >= {1'b0, count_reg};
        st.scan_end = idx_reg >= count_reg;
        st.match    = rdata == val_reg;
        st.out_free = !out_valid_reg || out_ready;
    end

    // Select RAM addresses and write data
    always_comb
    begin
        we    = cmd.we;
        wdata = cmd.wd_rdata ? rdata : val_reg;
        case (cmd.waddr)
            WA_COUNT: waddr = count_reg[AW-1:0];
            WA_P:     waddr = p_idx;
            default:  waddr = idx_reg[AW-1:0];
        endcase
        case (cmd.raddr)
            RA_P:      raddr = p_idx;
            RA_IDX:    raddr = idx_reg[AW-1:0];
            RA_IDX_M1: raddr = idx_m1[AW-1:0];
            default:   raddr = idx_p1[AW-1:0];
        endcase
    end

    ple_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Latch the request beat
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= in_data.func;
            pos_reg  <= in_data.position;
            val_reg  <= in_data.item_value;
        end
    end

    // Hold the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Advance the walking index
    always_ff @(posedge clk)
    begin
        case (cmd.idx_ld)
            IDX_COUNT: idx_reg <= count_reg;
            IDX_P:     idx_reg <= CW'(p_idx);
            IDX_ZERO:  idx_reg <= '0;
            default:
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_p1;
                end
                else if (cmd.idx_dec)
                begin
                    idx_reg <= idx_m1;
                end
            end
        endcase
    end

    // Collect the result fields
    always_ff @(posedge clk)
    begin
        if (cmd.clear_res)
        begin
            ok_reg   <= cmd.set_ok;
            oval_reg <= '0;
            oidx_reg <= '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.cap_rval)
            begin
                oval_reg <= rdata;
            end
            else if (cmd.cap_sval)
            begin
                oval_reg <= val_reg;
            end
            if (cmd.cap_idx)
            begin
                oidx_reg <= idx_reg;
            end
        end
    end

    assign oidx_x = XW'(oidx_reg);
    assign cnt_x  = XW'(count_reg);

    // Hold the response beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.ok          <= ok_reg;
            out_reg.out_value   <= oval_reg;
            out_reg.out_index   <= oidx_x[5:0];
            out_reg.count_after <= cnt_x[6:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
